// File: rtl/mpsm_pkg.sv
`timescale 1ns / 1ps

package mpsm_pkg;

  // Width of the match mask: slots at or above this index have no mask bit.
  localparam int unsigned MASK_BITS = 32;

  // Width of the reported slot number.
  localparam int unsigned SLOT_BITS = 5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_REBOOT  = 2'd1;
  localparam logic [1:0] CFG_ENABLE  = 2'd2;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_PRESS = 2'd0,
    OP_TICK  = 2'd1,
    OP_ADD   = 2'd2,
    OP_DEL   = 2'd3
  } op_e;

  // Completion codes of a result.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NULL    = 2'd2,
    STAT_MISSING = 2'd3
  } status_e;

  // One request as it enters the block.
  typedef struct packed {
    op_e         op;
    logic [15:0] handler_id;
    logic [15:0] match_count;
  } item_t;

  // One result as it leaves the block.
  typedef struct packed {
    status_e                  status;
    logic                     sequence_done;
    logic [15:0]              seq_count;
    logic                     reboot_request;
    logic [MASK_BITS-1:0]     match_mask;
    logic [SLOT_BITS-1:0]     slot;
  } result_t;

endpackage

// File: rtl/mpsm_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module mpsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/multi_press_sequence_matcher_top.sv
`timescale 1ns / 1ps

// Multi-press sequence matcher.
// Requests enter on item_i and are taken at a rising edge where start_i is high and busy_o
// is low. Each request produces exactly one result on result_o, shown for one cycle with
// done_o high; the receiver must take it in that cycle.
// Configuration writes use cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high and writes should only be issued while the block is idle.
// How each request is handled after the accepting edge:
//   press, unfinished tick, refused add or delete: result registered at that edge, busy_o stays low.
//   add: the occupancy flags are walked from slot 0 upwards, one slot a cycle, to the first free slot.
//   tick that finishes a sequence: every slot is read, one table RAM read a cycle.
//   delete: the table RAM is read from the top slot down until a live slot holds the handler.
// The table RAM read port sets the rate: at most one slot is examined per cycle. A new
// request may be accepted in the cycle where the previous result is shown.
// Reset clears the counter, the timer and the per-slot occupancy flags at once; the RAM
// itself is not swept, since a slot without its flag reads as empty.

module multi_press_sequence_matcher_top #(
  parameter int TABLE_ENTRIES = 32,
  parameter int COUNT_BITS    = 16,
  parameter int HANDLER_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  mpsm_pkg::item_t     item_i,
  output logic                done_o,
  output mpsm_pkg::result_t   result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W  = HANDLER_BITS + COUNT_BITS;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [USED_W-1:0]     USED_FULL = USED_W'(TABLE_ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_DEL,
    S_MATCH
  } state_e;

  state_e                    state_q;
  logic [TABLE_ENTRIES-1:0]  valid_q;
  logic [COUNT_BITS-1:0]     presses_q;
  logic [15:0]               quiet_q;
  logic [USED_W-1:0]         used_q;
  logic [IDX_W-1:0]          idx_q;
  logic                      issue_q;
  logic                      rd_live_q;
  logic                      rd_last_q;
  logic [IDX_W-1:0]          rd_idx_q;
  logic [HANDLER_BITS-1:0]   hid_q;
  logic [COUNT_BITS-1:0]     cnt_q;
  logic                      reboot_q;
  logic [mpsm_pkg::MASK_BITS-1:0] mask_q;
  logic                      done_q;
  mpsm_pkg::result_t         res_q;

  logic [15:0] timeout_q;
  logic [15:0] reboot_presses_q;
  logic        reboot_en_q;

  // Configuration registers; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q        <= 16'd30;
      reboot_presses_q <= 16'd3;
      reboot_en_q      <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mpsm_pkg::CFG_TIMEOUT: timeout_q        <= cfg_data_i;
        mpsm_pkg::CFG_REBOOT:  reboot_presses_q <= cfg_data_i;
        mpsm_pkg::CFG_ENABLE:  reboot_en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Request fields trimmed or extended to the internal widths.
  logic [31:0]             hid_ext;
  logic [31:0]             cnt_ext;
  logic [HANDLER_BITS-1:0] in_hid;
  logic [COUNT_BITS-1:0]   in_cnt;
  logic                    accept;

  assign hid_ext = 32'(item_i.handler_id);
  assign cnt_ext = 32'(item_i.match_count);
  assign in_hid  = hid_ext[HANDLER_BITS-1:0];
  assign in_cnt  = cnt_ext[COUNT_BITS-1:0];
  assign accept  = start_i && (state_q == S_IDLE);

  // Table RAM: each entry holds the handler id above the count.
  logic                    ram_we;
  logic                    ram_re;
  logic [ENT_W-1:0]        ram_rdata;
  logic [HANDLER_BITS-1:0] rd_hid;
  logic [COUNT_BITS-1:0]   rd_cnt;

  assign ram_we = (state_q == S_ADD) && !valid_q[idx_q];
  assign ram_re = issue_q && ((state_q == S_DEL) || (state_q == S_MATCH));
  assign rd_hid = ram_rdata[ENT_W-1:COUNT_BITS];
  assign rd_cnt = ram_rdata[COUNT_BITS-1:0];

  mpsm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i ({hid_q, cnt_q}),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Compare logic on the slot whose data has just come back.
  logic [6:0]                     rd_ext;
  logic [6:0]                     idx_ext;
  logic                           rd_used;
  logic [mpsm_pkg::MASK_BITS-1:0] mask_hit;
  logic [COUNT_BITS-1:0]          presses_inc;
  logic                           reboot_hit;
  logic [15:0]                    count_out;

  assign rd_ext   = 7'(rd_idx_q);
  assign idx_ext  = 7'(idx_q);
  assign rd_used  = rd_live_q && valid_q[rd_idx_q];

  always_comb begin
    mask_hit = mask_q;
    if (rd_used && (rd_cnt == presses_q) && (rd_ext < 7'(mpsm_pkg::MASK_BITS))) begin
      mask_hit[rd_ext[mpsm_pkg::SLOT_BITS-1:0]] = 1'b1;
    end
  end

  assign presses_inc = (presses_q != COUNT_MAX) ? presses_q + 1'b1 : presses_q;
  assign reboot_hit  = reboot_en_q && (32'(presses_q) == 32'(reboot_presses_q));
  assign count_out   = 16'(presses_q);

  function automatic mpsm_pkg::result_t make_res(
    mpsm_pkg::status_e              status,
    logic                           seq_done,
    logic [15:0]                    count,
    logic                           reboot,
    logic [mpsm_pkg::MASK_BITS-1:0] mask,
    logic [mpsm_pkg::SLOT_BITS-1:0] slot
  );
    mpsm_pkg::result_t r;
    r.status         = status;
    r.sequence_done  = seq_done;
    r.seq_count      = count;
    r.reboot_request = reboot;
    r.match_mask     = mask;
    r.slot           = slot;
    return r;
  endfunction

  // Sequencer: counter and timer updates, table scans and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      presses_q <= '0;
      quiet_q   <= '0;
      used_q    <= '0;
      idx_q     <= '0;
      issue_q   <= 1'b0;
      rd_live_q <= 1'b0;
      rd_last_q <= 1'b0;
      rd_idx_q  <= '0;
      hid_q     <= '0;
      cnt_q     <= '0;
      reboot_q  <= 1'b0;
      mask_q    <= '0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (item_i.op)
              mpsm_pkg::OP_PRESS: begin
                presses_q <= presses_inc;
                quiet_q   <= timeout_q;
                done_q    <= 1'b1;
                res_q     <= make_res(mpsm_pkg::STAT_OK, 1'b0, 16'(presses_inc), 1'b0,
                                      '0, '0);
              end
              mpsm_pkg::OP_TICK: begin
                if (presses_q == '0) begin
                  done_q <= 1'b1;
                  res_q  <= make_res(mpsm_pkg::STAT_OK, 1'b0, 16'd0, 1'b0, '0, '0);
                end else if (quiet_q > 16'd1) begin
                  quiet_q <= quiet_q - 16'd1;
                  done_q  <= 1'b1;
                  res_q   <= make_res(mpsm_pkg::STAT_OK, 1'b0, count_out, 1'b0, '0, '0);
                end else begin
                  // Sequence finished: scan the table for matching counts.
                  quiet_q   <= '0;
                  reboot_q  <= reboot_hit;
                  mask_q    <= '0;
                  idx_q     <= '0;
                  issue_q   <= 1'b1;
                  rd_live_q <= 1'b0;
                  state_q   <= S_MATCH;
                end
              end
              mpsm_pkg::OP_ADD: begin
                if (used_q >= USED_FULL) begin
                  done_q <= 1'b1;
                  res_q  <= make_res(mpsm_pkg::STAT_FULL, 1'b0, count_out, 1'b0, '0, '0);
                end else if (in_hid == '0) begin
                  done_q <= 1'b1;
                  res_q  <= make_res(mpsm_pkg::STAT_NULL, 1'b0, count_out, 1'b0, '0, '0);
                end else begin
                  hid_q   <= in_hid;
                  cnt_q   <= in_cnt;
                  idx_q   <= '0;
                  state_q <= S_ADD;
                end
              end
              mpsm_pkg::OP_DEL: begin
                if (in_hid == '0) begin
                  done_q <= 1'b1;
                  res_q  <= make_res(mpsm_pkg::STAT_NULL, 1'b0, count_out, 1'b0, '0, '0);
                end else begin
                  hid_q     <= in_hid;
                  idx_q     <= LAST_IDX;
                  issue_q   <= 1'b1;
                  rd_live_q <= 1'b0;
                  state_q   <= S_DEL;
                end
              end
              default: ;
            endcase
          end
        end

        S_ADD: begin
          // Walk the occupancy flags upwards to the first free slot.
          if (!valid_q[idx_q]) begin
            valid_q[idx_q] <= 1'b1;
            used_q         <= used_q + 1'b1;
            done_q         <= 1'b1;
            res_q          <= make_res(mpsm_pkg::STAT_OK, 1'b0, count_out, 1'b0, '0,
                                       idx_ext[mpsm_pkg::SLOT_BITS-1:0]);
            state_q        <= S_IDLE;
          end else if (idx_q == LAST_IDX) begin
            done_q  <= 1'b1;
            res_q   <= make_res(mpsm_pkg::STAT_FULL, 1'b0, count_out, 1'b0, '0, '0);
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        S_DEL: begin
          // Read downwards; the first live slot with the handler is the highest one.
          if (issue_q) begin
            if (idx_q == '0) begin
              issue_q <= 1'b0;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
          rd_live_q <= issue_q;
          rd_last_q <= (idx_q == '0);
          rd_idx_q  <= idx_q;
          if (rd_used && (rd_hid == hid_q)) begin
            valid_q[rd_idx_q] <= 1'b0;
            if (used_q != '0) begin
              used_q <= used_q - 1'b1;
            end
            done_q    <= 1'b1;
            res_q     <= make_res(mpsm_pkg::STAT_OK, 1'b0, count_out, 1'b0, '0,
                                  rd_ext[mpsm_pkg::SLOT_BITS-1:0]);
            issue_q   <= 1'b0;
            rd_live_q <= 1'b0;
            state_q   <= S_IDLE;
          end else if (rd_live_q && rd_last_q) begin
            done_q    <= 1'b1;
            res_q     <= make_res(mpsm_pkg::STAT_MISSING, 1'b0, count_out, 1'b0, '0, '0);
            rd_live_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end

        S_MATCH: begin
          // Read every slot upwards and collect the mask of matching counts.
          if (issue_q) begin
            if (idx_q == LAST_IDX) begin
              issue_q <= 1'b0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
          rd_live_q <= issue_q;
          rd_last_q <= (idx_q == LAST_IDX);
          rd_idx_q  <= idx_q;
          mask_q    <= mask_hit;
          if (rd_live_q && rd_last_q) begin
            presses_q <= '0;
            done_q    <= 1'b1;
            res_q     <= make_res(mpsm_pkg::STAT_OK, 1'b1, count_out, reboot_q, mask_hit,
                                  '0);
            rd_live_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: rtl/mpsm_checker.sv
`timescale 1ns / 1ps

// Port-level checks of the sequence matcher.
module mpsm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input mpsm_pkg::item_t   item_i,
  input logic              done_o,
  input mpsm_pkg::result_t result_o
);

  // A press is always answered in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (item_i.op == mpsm_pkg::OP_PRESS)) |=> done_o)
    else $error("press request not answered in the next cycle");

  // A request that raises busy is never answered in the cycle after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) ##1 busy_o |-> !done_o)
    else $error("result shown while a scan has just started");

  // A finished sequence carries an ok status and no slot number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.sequence_done) |->
      ((result_o.status == mpsm_pkg::STAT_OK) && (result_o.slot == '0)))
    else $error("finished sequence with bad status or slot");

  // Reboot request and match mask only come with a finished sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.sequence_done) |->
      (!result_o.reboot_request && (result_o.match_mask == '0)))
    else $error("reboot or mask outside a finished sequence");

  // A result never appears while the block is idle without a request before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(start_i && !busy_o) && !$past(busy_o)) |-> !done_o)
    else $error("result without a request");

endmodule

bind multi_press_sequence_matcher_top mpsm_checker u_mpsm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD = 8;
  localparam int TABLE_SLOTS = 32;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int RANDOM_PHASES = 6;
  localparam int END_SETTLE = 40;
  localparam longint RUN_LIMIT_NS = 64'd6_000_000;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Index beyond the register list.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  mpsm_pkg::item_t   item_i;
  logic              done_o;
  mpsm_pkg::result_t result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [15:0]       cfg_data_i;

  // Predicted state of the matcher and its registers.
  logic [15:0] cfg_timeout        = 16'd30;
  logic [15:0] cfg_reboot_presses = 16'd3;
  logic        cfg_reboot_en      = 1'b1;
  logic [15:0] cnt_presses        = '0;
  logic [15:0] cnt_quiet          = '0;
  logic [15:0] tbl_handler [TABLE_SLOTS] = '{default: '0};
  logic [15:0] tbl_count   [TABLE_SLOTS] = '{default: '0};
  int          tbl_used = 0;

  mpsm_pkg::result_t expected_results [$];
  int fail_count = 0;
  int requests_taken = 0;
  int results_seen = 0;
  int sequences_finished = 0;
  int reboots_seen = 0;
  int full_seen = 0;
  int null_seen = 0;
  int missing_seen = 0;

  multi_press_sequence_matcher_top #(
    .TABLE_ENTRIES(TABLE_SLOTS),
    .COUNT_BITS   (16),
    .HANDLER_BITS (16)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Applies one register write to the predicted configuration.
  function automatic void apply_register(logic [1:0] idx, logic [15:0] data);
    case (idx)
      mpsm_pkg::CFG_TIMEOUT: cfg_timeout = data;
      mpsm_pkg::CFG_REBOOT:  cfg_reboot_presses = data;
      mpsm_pkg::CFG_ENABLE:  cfg_reboot_en = data[0];
      default: ;
    endcase
  endfunction

  // Works out the result of one request and advances the predicted state.
  function automatic mpsm_pkg::result_t predict_result(mpsm_pkg::item_t req);
    mpsm_pkg::result_t res;
    logic              found;
    res = '0;
    res.status = mpsm_pkg::STAT_OK;
    found = 1'b0;
    case (req.op)
      mpsm_pkg::OP_PRESS: begin
        if (cnt_presses != COUNT_MAX) cnt_presses = cnt_presses + 16'd1;
        cnt_quiet = cfg_timeout;
        res.seq_count = cnt_presses;
      end
      mpsm_pkg::OP_TICK: begin
        if (cnt_presses != 16'd0 && cnt_quiet > 16'd1) begin
          cnt_quiet = cnt_quiet - 16'd1;
          res.seq_count = cnt_presses;
        end else if (cnt_presses != 16'd0) begin
          // The quiet time has run out: the sequence is finished.
          cnt_quiet = '0;
          res.sequence_done = 1'b1;
          res.seq_count = cnt_presses;
          res.reboot_request = cfg_reboot_en && (cnt_presses == cfg_reboot_presses);
          for (int s = 0; s < TABLE_SLOTS; s++) begin
            if (tbl_handler[s] != 16'd0 && tbl_count[s] == cnt_presses)
              res.match_mask[s] = 1'b1;
          end
          cnt_presses = '0;
        end
      end
      mpsm_pkg::OP_ADD: begin
        res.seq_count = cnt_presses;
        if (tbl_used >= TABLE_SLOTS) begin
          res.status = mpsm_pkg::STAT_FULL;
        end else if (req.handler_id == 16'd0) begin
          res.status = mpsm_pkg::STAT_NULL;
        end else begin
          for (int s = 0; s < TABLE_SLOTS; s++) begin
            if (!found && tbl_handler[s] == 16'd0) begin
              found = 1'b1;
              tbl_handler[s] = req.handler_id;
              tbl_count[s] = req.match_count;
              tbl_used++;
              res.slot = s[mpsm_pkg::SLOT_BITS-1:0];
            end
          end
          if (!found) res.status = mpsm_pkg::STAT_FULL;
        end
      end
      default: begin
        res.seq_count = cnt_presses;
        if (req.handler_id == 16'd0) begin
          res.status = mpsm_pkg::STAT_NULL;
        end else begin
          // The highest-numbered slot holding the handler is cleared.
          for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
            if (!found && tbl_handler[s] == req.handler_id) begin
              found = 1'b1;
              tbl_handler[s] = '0;
              tbl_count[s] = '0;
              if (tbl_used > 0) tbl_used--;
              res.slot = s[mpsm_pkg::SLOT_BITS-1:0];
            end
          end
          if (!found) res.status = mpsm_pkg::STAT_MISSING;
        end
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Checks each result against the oldest prediction, then records register writes and
  // newly taken requests.
  always @(posedge clk_i) begin : result_monitor
    mpsm_pkg::result_t want;
    if (done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result seen with no request outstanding");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        check_field("status", want.status, result_o.status);
        check_field("sequence_done", want.sequence_done, result_o.sequence_done);
        check_field("seq_count", want.seq_count, result_o.seq_count);
        check_field("reboot_request", want.reboot_request, result_o.reboot_request);
        check_field("match_mask", want.match_mask, result_o.match_mask);
        check_field("slot", want.slot, result_o.slot);
        if (want.sequence_done) sequences_finished++;
        if (want.reboot_request) reboots_seen++;
        if (want.status == mpsm_pkg::STAT_FULL) full_seen++;
        if (want.status == mpsm_pkg::STAT_NULL) null_seen++;
        if (want.status == mpsm_pkg::STAT_MISSING) missing_seen++;
      end
    end
    if (cfg_valid_i && cfg_ready_o) apply_register(cfg_index_i, cfg_data_i);
    if (start_i && !busy_o) begin
      expected_results.push_back(predict_result(item_i));
      requests_taken++;
    end
  end

  function automatic mpsm_pkg::item_t make_item(mpsm_pkg::op_e op, logic [15:0] hid,
                                                logic [15:0] cnt);
    mpsm_pkg::item_t req;
    req.op = op;
    req.handler_id = hid;
    req.match_count = cnt;
    return req;
  endfunction

  // Sends one request after a random pause; start stays high once the request is taken, so
  // a following request with no pause goes straight in.
  task automatic send_request(mpsm_pkg::item_t req, int max_gap);
    int gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= req;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Presses or ticks with random content in the fields that they ignore.
  task automatic send_op(mpsm_pkg::op_e op, int n, int max_gap);
    for (int k = 0; k < n; k++) begin
      send_request(make_item(op, 16'($urandom), 16'($urandom)), max_gap);
    end
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_drained(int settle);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Reset register values: three presses and thirty quiet ticks request a reboot.
  task automatic test_reset_defaults();
    send_op(mpsm_pkg::OP_TICK, 1, 11);
    send_op(mpsm_pkg::OP_PRESS, 3, 11);
    send_op(mpsm_pkg::OP_TICK, 30, 11);
    wait_drained(4);
  endtask

  // Refusals, filling the table, duplicate handlers and reuse of a freed slot.
  task automatic test_table_ops();
    logic [15:0] hid;
    logic [15:0] cnt;
    write_register(mpsm_pkg::CFG_TIMEOUT, 16'd1);
    send_request(make_item(mpsm_pkg::OP_ADD, 16'd0, 16'($urandom)), 11);
    send_request(make_item(mpsm_pkg::OP_DEL, 16'd0, 16'($urandom)), 11);
    send_request(make_item(mpsm_pkg::OP_DEL, 16'h1234, 16'($urandom)), 11);
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      if (s == TABLE_SLOTS - 1) hid = 16'hFFFF;
      else if (s % 8 == 5) hid = 16'h00A5;
      else hid = 16'(s + 1);
      if (s == 0) cnt = 16'd0;
      else if (s == 30) cnt = COUNT_MAX;
      else cnt = 16'd2;
      send_request(make_item(mpsm_pkg::OP_ADD, hid, cnt), 11);
    end
    // Fullness is reported ahead of a null handler.
    send_request(make_item(mpsm_pkg::OP_ADD, 16'hBEEF, 16'd2), 11);
    send_request(make_item(mpsm_pkg::OP_ADD, 16'd0, 16'd2), 11);
    send_op(mpsm_pkg::OP_PRESS, 2, 11);
    send_op(mpsm_pkg::OP_TICK, 1, 11);
    send_request(make_item(mpsm_pkg::OP_DEL, 16'h00A5, 16'($urandom)), 11);
    send_request(make_item(mpsm_pkg::OP_DEL, 16'h00A5, 16'($urandom)), 11);
    send_request(make_item(mpsm_pkg::OP_DEL, 16'h9999, 16'($urandom)), 11);
    send_request(make_item(mpsm_pkg::OP_ADD, 16'h7777, COUNT_MAX), 11);
    wait_drained(4);
  endtask

  // Zero timeout, timer restart and the reboot request settings.
  task automatic test_timer_corners();
    write_register(mpsm_pkg::CFG_TIMEOUT, 16'd0);
    write_register(mpsm_pkg::CFG_ENABLE, 16'd0);
    write_register(mpsm_pkg::CFG_REBOOT, 16'd2);
    send_op(mpsm_pkg::OP_PRESS, 2, 11);
    send_op(mpsm_pkg::OP_TICK, 2, 11);
    wait_drained(4);
    // The unused index must leave every register alone.
    write_register(REG_UNUSED, 16'hFFFF);
    write_register(mpsm_pkg::CFG_ENABLE, 16'hFFFF);
    write_register(mpsm_pkg::CFG_REBOOT, 16'd0);
    send_op(mpsm_pkg::OP_PRESS, 1, 11);
    send_op(mpsm_pkg::OP_TICK, 1, 11);
    wait_drained(4);
    write_register(mpsm_pkg::CFG_REBOOT, 16'd1);
    write_register(mpsm_pkg::CFG_TIMEOUT, 16'd2);
    send_op(mpsm_pkg::OP_PRESS, 1, 11);
    send_op(mpsm_pkg::OP_TICK, 2, 11);
    // A second press restarts the quiet time.
    send_op(mpsm_pkg::OP_PRESS, 1, 11);
    send_op(mpsm_pkg::OP_TICK, 1, 11);
    send_op(mpsm_pkg::OP_PRESS, 1, 11);
    send_op(mpsm_pkg::OP_TICK, 2, 11);
    wait_drained(4);
  endtask

  function automatic logic [15:0] pick_handler();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 15) return 16'($urandom_range(1, 6));
    if (roll < 18) return 16'($urandom);
    if (roll == 18) return 16'd0;
    return 16'hFFFF;
  endfunction

  function automatic logic [15:0] pick_count();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(1, 5));
  endfunction

  // Mostly complete press sequences mixed with table maintenance, plus broken sequences
  // and requests with arbitrary content.
  task automatic test_random_traffic();
    logic [15:0] leftover [$];
    logic [15:0] hid;
    int sent;
    int t;
    int n;
    int pick;
    int gap_max;
    int add_weight;
    // Start from an empty table.
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      if (tbl_handler[s] != 16'd0) leftover.push_back(tbl_handler[s]);
    end
    foreach (leftover[v]) begin
      send_request(make_item(mpsm_pkg::OP_DEL, leftover[v], 16'($urandom)), 11);
    end
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained(4);
      t = $urandom_range(1, 6);
      write_register(mpsm_pkg::CFG_TIMEOUT, 16'(t));
      write_register(mpsm_pkg::CFG_REBOOT, 16'($urandom_range(1, 5)));
      write_register(mpsm_pkg::CFG_ENABLE, 16'($urandom));
      if (phase % 2 == 1) write_register(REG_UNUSED, 16'($urandom));
      gap_max = (phase == 2) ? 0 : 11;
      add_weight = (phase == 4) ? 45 : 25;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
          send_op(mpsm_pkg::OP_PRESS, n, gap_max);
          sent += n;
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, t - 1) : t;
          send_op(mpsm_pkg::OP_TICK, n, gap_max);
          sent += n;
        end else if (pick < 45 + add_weight) begin
          send_request(make_item(mpsm_pkg::OP_ADD, pick_handler(), pick_count()), gap_max);
          sent++;
        end else if (pick < 90) begin
          n = $urandom_range(0, 9);
          if (n < 7) hid = 16'($urandom_range(1, 6));
          else if (n < 9) hid = tbl_handler[$urandom_range(0, TABLE_SLOTS - 1)];
          else hid = 16'($urandom);
          send_request(make_item(mpsm_pkg::OP_DEL, hid, 16'($urandom)), gap_max);
          sent++;
        end else begin
          send_request(make_item(mpsm_pkg::op_e'($urandom_range(0, 3)), 16'($urandom),
                                 16'($urandom)),
                       gap_max);
          sent++;
        end
        if ($urandom_range(0, 29) == 0) wait_drained(0);
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    item_i      <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= mpsm_pkg::CFG_TIMEOUT;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_table_ops();
    test_timer_corners();
    test_random_traffic();
    wait_drained(END_SETTLE);
    $display("Run covered %0d requests and %0d results, %0d finished sequences, %0d reboots.",
             requests_taken, results_seen, sequences_finished, reboots_seen);
    $display("Refusals seen: %0d table full, %0d null handler, %0d unknown handler.",
             full_seen, null_seen, missing_seen);
    if (fail_count == 0) begin
      $display("PASS multi_press_sequence_matcher_top");
    end else begin
      $display("FAIL multi_press_sequence_matcher_top");
    end
    $finish;
  end

  // Guard against a block that stops answering.
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL multi_press_sequence_matcher_top");
    $finish;
  end

endmodule
